// ===== design/bss_pkg.sv =====
`timescale 1ns / 1ps
// bss_pkg: shared types and codes for the backend server selector.
// No dependencies; imported by bss_store and backend_server_selector.
package bss_pkg;

  // Field widths
  localparam int OP_W     = 3;
  localparam int IDX_W    = 4;
  localparam int VAL_W    = 16;
  localparam int MODE_W   = 2;
  localparam int SCNT_W   = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Servers reachable through a 4-bit index
  localparam int IDX_SPACE = 1 << IDX_W;
  localparam int MAX_SERVERS_DEF = 16;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_SELECT      = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_UP      = 3'd1;
  localparam logic [OP_W-1:0] OP_REPORT_LOAD = 3'd2;
  localparam logic [OP_W-1:0] OP_CONN_OPEN   = 3'd3;
  localparam logic [OP_W-1:0] OP_CONN_CLOSE  = 3'd4;

  // Selection modes
  localparam logic [MODE_W-1:0] MODE_ROUND_ROBIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LEAST_CONN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LEAST_LOAD  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALGORITHM_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_COUNT   = 1'd1;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [IDX_W-1:0] server_index;
    logic [VAL_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] selected_server;
    logic             none_available;
  } out_res_t;

  // Store access, one read and one write address per cycle
  typedef struct packed {
    logic [IDX_W-1:0] rd_idx;
    logic             cnt_we;
    logic             load_we;
    logic [IDX_W-1:0] wr_idx;
    logic [VAL_W-1:0] cnt_wdata;
    logic [VAL_W-1:0] load_wdata;
  } store_req_t;

  typedef struct packed {
    logic [VAL_W-1:0] cnt;
    logic [VAL_W-1:0] load;
  } store_rsp_t;

endpackage

// ===== design/backend_server_selector.sv =====
`timescale 1ns / 1ps
// backend_server_selector: picks a backend server per new connection.
// Depends on bss_pkg and bss_store.
//
//  port group  | dir | handshake          | payload
//  ------------+-----+--------------------+---------------------------------
//  in_*        | in  | in_valid/in_ready  | in_data  (opcode, index, value)
//  out_*       | out | out_valid/out_ready| out_data (selected, none flag)
//  cfg_*       | in  | cfg_we only        | cfg_idx, cfg_wdata
//
// Steps: set up/down, report load and unknown opcodes finish in idle;
// connection open/close read the count, then write it back. Select scans
// the servers in use (round robin stops at the first up one; least modes
// add a drain compare); the single store read port visits one entry a cycle.
// Reset: synchronous, active low; store entries read as zero via valid bits.
// Stalls: a finished result sits in the output register while new requests
// are taken; a select waits in its final state only if that register is full.
module backend_server_selector #(
  parameter int MAX_SERVERS = bss_pkg::MAX_SERVERS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  bss_pkg::in_req_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output bss_pkg::out_res_t                  out_data,
  input  logic                               cfg_we,
  input  logic [bss_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [bss_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import bss_pkg::*;

  // Only 16 servers are addressable, whatever the store could hold
  localparam int DEPTH = (MAX_SERVERS < IDX_SPACE) ? MAX_SERVERS : IDX_SPACE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [SCNT_W-1:0] DEPTH_N = SCNT_W'(DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RMW   = 5'b00010,  // count write-back after read
    ST_SCAN  = 5'b00100,  // one entry per cycle
    ST_DRAIN = 5'b01000,  // last compare of a least scan
    ST_FIN   = 5'b10000   // hand result to output register
  } state_t;

  state_t state_r, state_nxt;

  // Configuration
  logic [MODE_W-1:0] mode_r;
  logic [SCNT_W-1:0] count_r;

  // Up flags live in flops, counts and loads in the store
  logic [DEPTH-1:0] up_r;
  logic [AW-1:0]    rr_last_r;

  // Scan state
  logic [AW-1:0]    scan_i_r;
  logic [AW-1:0]    cand_r;
  logic [AW-1:0]    sel_r;
  logic             found_r;
  logic [VAL_W-1:0] best_r;
  logic             cmp_vld_r;
  logic [AW-1:0]    cmp_idx_r;

  // Pending count update
  logic [AW-1:0]    ev_idx_r;
  logic             ev_open_r;

  logic             out_valid_r;
  out_res_t         out_data_r;

  store_req_t       st_req;
  store_rsp_t       st_rsp;

  logic              in_acc;
  logic              idx_ok;
  logic              is_least;
  logic [SCNT_W-1:0] n_use;
  logic              last_step;
  logic              up_cand;
  logic              fin_go;
  logic [SCNT_W-1:0] last_inc;
  logic [AW-1:0]     cand_start;
  logic [SCNT_W-1:0] cand_inc;
  logic [AW-1:0]     cand_next;
  logic [VAL_W-1:0]  metric;
  logic              cmp_hit;
  logic [AW-1:0]     in_addr;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign in_addr  = in_data.server_index[AW-1:0];
  assign idx_ok   = ({1'b0, in_data.server_index} < DEPTH_N);
  assign is_least = (mode_r == MODE_LEAST_CONN) || (mode_r == MODE_LEAST_LOAD);

  // Servers in use: count clamped to 1..DEPTH
  assign n_use = (count_r == '0) ? SCNT_W'(1) :
                 ((count_r > DEPTH_N) ? DEPTH_N : count_r);

  assign last_step = (SCNT_W'(scan_i_r) == (n_use - SCNT_W'(1)));

  // Round robin: start after last pick, wrap at n_use
  assign last_inc   = SCNT_W'(rr_last_r) + SCNT_W'(1);
  assign cand_start = (last_inc >= n_use) ? '0 : AW'(last_inc);
  assign cand_inc   = SCNT_W'(cand_r) + SCNT_W'(1);
  assign cand_next  = (cand_inc >= n_use) ? '0 : AW'(cand_inc);
  assign up_cand    = up_r[cand_r];

  // Least modes: strict less-than keeps the lowest index on ties
  assign metric  = (mode_r == MODE_LEAST_LOAD) ? st_rsp.load : st_rsp.cnt;
  assign cmp_hit = cmp_vld_r && up_r[cmp_idx_r] && (!found_r || (metric < best_r));

  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.opcode)
            OP_SELECT: state_nxt = ST_SCAN;
            OP_CONN_OPEN, OP_CONN_CLOSE: begin
              if (idx_ok) begin
                state_nxt = ST_RMW;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RMW: state_nxt = ST_IDLE;
      ST_SCAN: begin
        if (is_least) begin
          if (last_step) begin
            state_nxt = ST_DRAIN;
          end
        end else if (up_cand || last_step) begin
          state_nxt = ST_FIN;
        end
      end
      ST_DRAIN: state_nxt = ST_FIN;
      ST_FIN: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Store port: scan address while scanning, else the request's index
  always_comb begin
    st_req.rd_idx     = (state_r == ST_SCAN) ? IDX_W'(scan_i_r) : in_data.server_index;
    st_req.load_we    = in_acc && (in_data.opcode == OP_REPORT_LOAD) && idx_ok;
    st_req.cnt_we     = (state_r == ST_RMW);
    st_req.wr_idx     = (state_r == ST_RMW) ? IDX_W'(ev_idx_r) : in_data.server_index;
    st_req.load_wdata = in_data.value;
    if (ev_open_r) begin
      st_req.cnt_wdata = (st_rsp.cnt == '1) ? st_rsp.cnt : st_rsp.cnt + VAL_W'(1);
    end else begin
      st_req.cnt_wdata = (st_rsp.cnt == '0) ? st_rsp.cnt : st_rsp.cnt - VAL_W'(1);
    end
  end

  bss_store #(
    .MAX_SERVERS(MAX_SERVERS)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (st_req),
    .rsp   (st_rsp)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_ROUND_ROBIN;
      count_r     <= SCNT_W'(1);
      up_r        <= '0;
      rr_last_r   <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= (state_r == ST_SCAN) && is_least;

      if (cfg_we) begin
        case (cfg_idx)
          CFG_ALGORITHM_MODE: mode_r  <= cfg_wdata[MODE_W-1:0];
          CFG_SERVER_COUNT:   count_r <= cfg_wdata[SCNT_W-1:0];
          default: ;
        endcase
      end

      if (in_acc && (in_data.opcode == OP_SET_UP) && idx_ok) begin
        up_r[in_addr] <= in_data.value[0];
      end

      if (fin_go) begin
        out_valid_r <= 1'b1;
        if (found_r && !is_least) begin
          rr_last_r <= sel_r;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Scan and payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ev_idx_r  <= in_addr;
      ev_open_r <= (in_data.opcode == OP_CONN_OPEN);
      scan_i_r  <= '0;
      cand_r    <= cand_start;
      found_r   <= 1'b0;
    end else if (state_r == ST_SCAN) begin
      scan_i_r <= AW'(SCNT_W'(scan_i_r) + SCNT_W'(1));
      if (!is_least) begin
        if (up_cand) begin
          found_r <= 1'b1;
          sel_r   <= cand_r;
        end else begin
          cand_r <= cand_next;
        end
      end
    end

    cmp_idx_r <= scan_i_r;
    if (cmp_hit) begin
      found_r <= 1'b1;
      sel_r   <= cmp_idx_r;
      best_r  <= metric;
    end

    if (fin_go) begin
      out_data_r.selected_server <= found_r ? IDX_W'(sel_r) : '0;
      out_data_r.none_available  <= !found_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A result only appears out of the final state
  a_rose_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_FIN))
    else $error("result raised outside final state");

  // No server means index zero
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.none_available |-> out_data.selected_server == '0)
    else $error("none_available with nonzero server");

  // A select always starts a scan
  a_select_scans: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.opcode == OP_SELECT) |=> state_r == ST_SCAN)
    else $error("select did not start a scan");

  // Compare stage only runs behind the scan
  a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> (state_r == ST_SCAN) || (state_r == ST_DRAIN))
    else $error("compare outside scan");

endmodule

// ===== design/bss_store.sv =====
`timescale 1ns / 1ps
// bss_store: connection count and load memories, registered read.
// Depends on bss_pkg. Per-entry valid bits make unwritten entries read as zero.
module bss_store #(
  parameter int MAX_SERVERS = bss_pkg::MAX_SERVERS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bss_pkg::store_req_t req,
  output bss_pkg::store_rsp_t rsp
);
  import bss_pkg::*;

  localparam int DEPTH = (MAX_SERVERS < IDX_SPACE) ? MAX_SERVERS : IDX_SPACE;
  localparam int AW    = $clog2(DEPTH);

  logic [VAL_W-1:0] cnt_mem  [DEPTH];
  logic [VAL_W-1:0] load_mem [DEPTH];
  logic [DEPTH-1:0] cnt_vld_r;
  logic [DEPTH-1:0] load_vld_r;
  store_rsp_t       rsp_r;

  logic [AW-1:0] wa;
  logic [AW-1:0] ra;

  assign wa = req.wr_idx[AW-1:0];
  assign ra = req.rd_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (req.cnt_we) begin
      cnt_mem[wa] <= req.cnt_wdata;
    end
    if (req.load_we) begin
      load_mem[wa] <= req.load_wdata;
    end
    rsp_r.cnt  <= cnt_vld_r[ra]  ? cnt_mem[ra]  : '0;
    rsp_r.load <= load_vld_r[ra] ? load_mem[ra] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r  <= '0;
      load_vld_r <= '0;
    end else begin
      if (req.cnt_we) begin
        cnt_vld_r[wa] <= 1'b1;
      end
      if (req.load_we) begin
        load_vld_r[wa] <= 1'b1;
      end
    end
  end

  assign rsp = rsp_r;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for backend_server_selector.
// Depends on bss_pkg and the design files; a scoreboard class predicts every pick
// from its own copy of the server table and checks each result in order.
module tb;
  import bss_pkg::*;

  localparam int RESET_CYCLES     = 7;
  localparam int DRAIN_CYCLES     = 40;     // outlasts the longest select
  localparam int WATCHDOG_LIMIT   = 4000;   // long hold plus longest gaps, many times over
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES    = 12;
  localparam int PHASE_REQUESTS   = 150;
  localparam int SAT_OPENS        = 24;     // a run of opens on one server
  localparam int HOLD_PHASE       = 5;
  localparam int PAUSE_PHASE      = 7;
  localparam int STEADY_PHASE     = 8;

  // Codes the package leaves unnamed
  localparam logic [OP_W-1:0]   OP_LAST       = '1;
  localparam logic [MODE_W-1:0] MODE_RESERVED = '1;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_req_t   in_data;
  logic      out_valid;
  logic      out_ready;
  out_res_t  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bit sender_gaps_on;
  bit receiver_stalls_on;
  int long_holds_asked;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  backend_server_selector u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow server table plus the queue of picks still owed by the block.
  class selection_scoreboard;
    bit               server_up  [IDX_SPACE];
    logic [VAL_W-1:0] conn_count [IDX_SPACE];
    logic [VAL_W-1:0] load       [IDX_SPACE];
    int               rr_last;
    logic [MODE_W-1:0] mode;
    logic [SCNT_W-1:0] count_reg;
    out_res_t         expected_picks[$];
    int               errors;

    function new();
      foreach (server_up[i]) begin
        server_up[i]  = 1'b0;
        conn_count[i] = '0;
        load[i]       = '0;
      end
      rr_last   = 0;
      mode      = MODE_ROUND_ROBIN;
      count_reg = SCNT_W'(1);
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_ALGORITHM_MODE) mode = data[MODE_W-1:0];
      else count_reg = data[SCNT_W-1:0];
    endfunction

    // 0 acts as 1, anything past the table as the full table
    function int servers_in_use();
      int n;
      n = count_reg;
      if (n < 1) n = 1;
      if (n > MAX_SERVERS_DEF) n = MAX_SERVERS_DEF;
      return n;
    endfunction

    function out_res_t predict_selection();
      out_res_t         pick;
      int               n;
      int               cand;
      bit               found;
      logic [VAL_W-1:0] best;
      logic [VAL_W-1:0] metric;
      n     = servers_in_use();
      found = 1'b0;
      pick  = '0;
      best  = '0;
      if (mode == MODE_LEAST_CONN || mode == MODE_LEAST_LOAD) begin
        // strict less-than keeps the lowest index on a tie
        for (int i = 0; i < n; i++) begin
          metric = (mode == MODE_LEAST_LOAD) ? load[i] : conn_count[i];
          if (server_up[i] && (!found || metric < best)) begin
            best                 = metric;
            pick.selected_server = IDX_W'(i);
            found                = 1'b1;
          end
        end
      end else begin
        // round robin, reserved mode included; a stale pointer restarts at 0
        cand = rr_last + 1;
        if (cand >= n) cand = 0;
        for (int i = 0; i < n && !found; i++) begin
          if (server_up[cand]) begin
            pick.selected_server = IDX_W'(cand);
            found                = 1'b1;
          end else begin
            cand++;
            if (cand >= n) cand = 0;
          end
        end
        if (found) rr_last = cand;
      end
      pick.none_available = !found;
      return pick;
    endfunction

    function void note_request(in_req_t req);
      case (req.opcode)
        OP_SELECT:      expected_picks.push_back(predict_selection());
        OP_SET_UP:      server_up[req.server_index] = req.value[0];
        OP_REPORT_LOAD: load[req.server_index] = req.value;
        OP_CONN_OPEN: begin
          if (conn_count[req.server_index] != '1)
            conn_count[req.server_index] = conn_count[req.server_index] + 1'b1;
        end
        OP_CONN_CLOSE: begin
          if (conn_count[req.server_index] != '0)
            conn_count[req.server_index] = conn_count[req.server_index] - 1'b1;
        end
        default: ;  // unused opcodes are dropped
      endcase
    endfunction

    function void check_pick(out_res_t got);
      out_res_t want;
      if (expected_picks.size() == 0) begin
        $display("%0t: result with none pending: expected nothing, actual sel=%0d none=%0b",
                 $time, got.selected_server, got.none_available);
        errors++;
        return;
      end
      want = expected_picks.pop_front();
      if (got.selected_server !== want.selected_server) begin
        $display("%0t: selected_server expected %0d actual %0d",
                 $time, want.selected_server, got.selected_server);
        errors++;
      end
      if (got.none_available !== want.none_available) begin
        $display("%0t: none_available expected %0b actual %0b",
                 $time, want.none_available, got.none_available);
        errors++;
      end
    endfunction

    function int pending();
      return expected_picks.size();
    endfunction
  endclass

  selection_scoreboard sb;

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Called at a falling edge; returns at a falling edge with valid still high
  // only when the next request follows with no gap.
  task automatic send_request(input in_req_t req);
    int gap;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
    @(negedge clk);
    gap = sender_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_fields(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic [VAL_W-1:0] value);
    in_req_t req;
    req.opcode       = op;
    req.server_index = idx;
    req.value        = value;
    send_request(req);
  endtask

  task automatic wait_for_results();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Registers change only with the block idle: every pick back, and the
  // trailing event requests (which owe nothing) given time to retire.
  task automatic configure(input logic [CFG_DATA_W-1:0] mode_data,
                           input logic [CFG_DATA_W-1:0] count_data);
    in_valid <= 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_ALGORITHM_MODE;
    cfg_wdata <= mode_data;
    sb.write_reg(CFG_ALGORITHM_MODE, mode_data);
    @(negedge clk);
    cfg_idx   <= CFG_SERVER_COUNT;
    cfg_wdata <= count_data;
    sb.write_reg(CFG_SERVER_COUNT, count_data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Indexes lean toward servers in use; loads lean small so least-load ties happen.
  function automatic in_req_t random_request(int select_pct);
    in_req_t req;
    int      r;
    int      n;
    n                = sb.servers_in_use();
    req.value        = VAL_W'($urandom);
    req.server_index = ($urandom_range(0, 99) < 80) ? IDX_W'($urandom_range(0, n - 1))
                                                    : IDX_W'($urandom_range(0, IDX_SPACE - 1));
    if ($urandom_range(0, 99) < select_pct) begin
      req.opcode = OP_SELECT;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        req.opcode   = OP_SET_UP;
        req.value[0] = ($urandom_range(0, 99) < 65);
      end else if (r < 50) begin
        req.opcode = OP_REPORT_LOAD;
        if ($urandom_range(0, 1) == 0) req.value = VAL_W'($urandom_range(0, 3));
      end else if (r < 75) begin
        req.opcode = OP_CONN_OPEN;
      end else if (r < 95) begin
        req.opcode = OP_CONN_CLOSE;
      end else begin
        req.opcode = OP_W'($urandom_range(int'(OP_CONN_CLOSE) + 1, int'(OP_LAST)));
      end
    end
    return req;
  endfunction

  // Result side: random stalls, plus one long hold on request from the main flow
  initial begin
    int stall;
    int holds_done;
    out_ready  = 1'b0;
    stall      = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (holds_done != long_holds_asked) begin
        holds_done = long_holds_asked;
        stall      = LONG_HOLD_CYCLES;
      end
      if (stall == 0 && receiver_stalls_on && $urandom_range(0, 3) == 0) stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_pick(out_data);
  end

  // Ends a hung run: counts cycles in which no request and no result moved
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog, nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] mode_data;
    logic [CFG_DATA_W-1:0] count_data;
    sb                 = new();
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_data            = '0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_wdata          = '0;
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
    long_holds_asked   = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // --- directed: reset state is round robin over one server, all down ---
    send_fields(OP_SELECT, '0, '0);                 // nothing up
    send_fields(OP_SET_UP, 4'd15, '1);              // beyond count: stored, not seen
    send_fields(OP_SELECT, '0, '0);
    send_fields(OP_CONN_CLOSE + 3'd1, 4'd3, '1);    // unused opcodes, no result
    send_fields(OP_CONN_CLOSE + 3'd2, 4'd3, '1);
    send_fields(OP_LAST, 4'd3, '1);
    send_fields(OP_SET_UP, '0, 16'd1);
    send_fields(OP_SELECT, '0, '0);                 // wraps onto itself
    send_fields(OP_SELECT, '0, '0);
    send_fields(OP_CONN_CLOSE, '0, '0);             // close at zero holds zero
    send_fields(OP_REPORT_LOAD, 4'd15, '1);
    send_fields(OP_REPORT_LOAD, '0, '0);

    configure(CFG_DATA_W'(MODE_ROUND_ROBIN), CFG_DATA_W'(16));
    send_fields(OP_SELECT, '0, '0);                 // skips the down middle
    send_fields(OP_SELECT, '0, '0);                 // wraps back to 0
    send_fields(OP_SELECT, '0, '0);

    configure(CFG_DATA_W'(MODE_LEAST_CONN), CFG_DATA_W'(31));   // count clamps to 16
    send_fields(OP_CONN_OPEN, '0, '0);
    send_fields(OP_CONN_OPEN, '0, '0);
    send_fields(OP_SELECT, '0, '0);
    send_fields(OP_SET_UP, 4'd7, 16'hFFFE);         // only bit 0 is the up flag

    configure(CFG_DATA_W'(MODE_LEAST_LOAD), '0);    // count 0 acts as 1
    send_fields(OP_SELECT, '0, '0);
    configure(CFG_DATA_W'(MODE_LEAST_LOAD), CFG_DATA_W'(16));
    send_fields(OP_SELECT, '0, '0);

    // pointer sits at 15, now past the count: search restarts at 0
    configure(CFG_DATA_W'(MODE_RESERVED), CFG_DATA_W'(4));
    send_fields(OP_SELECT, '0, '0);
    send_fields(OP_SELECT, '0, '0);
    send_fields(OP_SET_UP, 4'd2, 16'd1);
    send_fields(OP_SELECT, '0, '0);

    // --- random phases, each under a fresh configuration ---
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      mode_data = CFG_DATA_W'($urandom);
      if (p < 4) mode_data[MODE_W-1:0] = MODE_W'(p);   // every mode, reserved one too
      case (p % 6)
        0:       count_data = CFG_DATA_W'(16);
        1:       count_data = CFG_DATA_W'(31);
        2:       count_data = '0;
        3:       count_data = CFG_DATA_W'(1);
        default: count_data = CFG_DATA_W'($urandom_range(2, 15));
      endcase
      configure(mode_data, count_data);
      sender_gaps_on     = !(p == HOLD_PHASE || p == STEADY_PHASE);
      receiver_stalls_on = (p != STEADY_PHASE);
      // back-pressure: receiver stops while selects keep coming, so the
      // output register fills and the input side must stall
      if (p == HOLD_PHASE) long_holds_asked++;
      for (int k = 0; k < PHASE_REQUESTS; k++) begin
        if (p == PAUSE_PHASE && k == PHASE_REQUESTS / 2) begin
          in_valid <= 1'b0;
          @(negedge clk);
          wait_for_results();
        end
        send_request(random_request(p == HOLD_PHASE ? 70 : 35));
      end
    end

    // --- connection counts: a run of opens on server 0, then probe ---
    configure(CFG_DATA_W'(MODE_LEAST_CONN), CFG_DATA_W'(2));
    sender_gaps_on = 1'b0;
    send_fields(OP_SET_UP, '0, 16'd1);
    send_fields(OP_SET_UP, 4'd1, 16'd1);
    repeat (SAT_OPENS) send_fields(OP_CONN_OPEN, '0, '0);
    send_fields(OP_SELECT, '0, '0);
    send_fields(OP_CONN_CLOSE, '0, '0);
    send_fields(OP_CONN_OPEN, '0, '0);
    send_fields(OP_CONN_OPEN, '0, '0);
    send_fields(OP_SET_UP, 4'd1, '0);
    send_fields(OP_SELECT, '0, '0);

    in_valid <= 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
